// ----- src/aavr_pkg.sv -----
// ----------------------------------------------------------------------------
// aavr_pkg
// Constants, tables and types for the axis-angle vector rotation unit.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int TRIG_ITERATIONS = 16;  // CORDIC steps, 8 to 24
  localparam int TABLE_LEN       = 24;
  localparam int PIPE_LEN        = TRIG_ITERATIONS + 11;
  localparam int SIDE_LEN        = TRIG_ITERATIONS + 8;

  localparam logic [31:0] FULL_TURN    = 32'd23592960;  // 360 deg, Q16.16
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;   // 90 deg, Q16.16
  // 2^31 mod FULL_TURN, undoes the offset that makes the angle unsigned
  localparam logic [24:0] MOD_OFFSET   = 25'd524288;
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic signed [29:0] ONE_Q28 = 30'sd268435456;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // vector and axis, carried alongside the angle path
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [17:0] axis_x;
    logic signed [17:0] axis_y;
    logic signed [17:0] axis_z;
  } side_t;

endpackage

// ----- src/aavr_in_if.sv -----
// ----------------------------------------------------------------------------
// aavr_in_if
// Input stream: vector, axis and angle with valid/ready.
// ----------------------------------------------------------------------------
interface aavr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [17:0] axis_x;
  logic signed [17:0] axis_y;
  logic signed [17:0] axis_z;
  logic signed [31:0] angle_deg;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  angle_deg, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                angle_deg, output ready);
endinterface

// ----- src/aavr_out_if.sv -----
// ----------------------------------------------------------------------------
// aavr_out_if
// Output stream: rotated vector and overflow flag with valid/ready.
// ----------------------------------------------------------------------------
interface aavr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic               overflow;

  modport source (output valid, rot_x, rot_y, rot_z, overflow, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, overflow, output ready);
endinterface

// ----- src/axis_angle_vector_rotation_unit.sv -----
// Throughput: one item per cycle while the output is not held; each CORDIC step has a register stage of its own.
// The whole pipeline holds while a result waits at the output register.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_unit
// Rotates a Q16.16 vector about a unit axis by an angle in degrees (Rodrigues
// form), with pipelined angle reduction, CORDIC and matrix product.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_unit (
  input  logic       clk,
  input  logic       rst,
  aavr_in_if.sink    din,
  aavr_out_if.source dout
);
  import aavr_pkg::*;

  localparam int N = TRIG_ITERATIONS;

  logic en;
  logic vld [PIPE_LEN];
  side_t side [SIDE_LEN];

  assign en        = !vld[PIPE_LEN-1] || dout.ready;
  assign din.ready = en;
  assign dout.valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LEN; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= din.valid;
      for (int k = 1; k < PIPE_LEN; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{din.vec_x, din.vec_y, din.vec_z,
                   din.axis_x, din.axis_y, din.axis_z};
      for (int k = 1; k < SIDE_LEN; k++) side[k] <= side[k-1];
    end
  end

  // ---- angle reduction: restoring subtraction of FULL_TURN multiples ----
  logic [31:0] red1, red1_next, red2, red2_next;

  always_comb begin
    // offset by 2^31 to work unsigned
    red1_next = {~din.angle_deg[31], din.angle_deg[30:0]};
    for (int k = 7; k >= 4; k--) begin
      if (red1_next >= (FULL_TURN << k)) red1_next = red1_next - (FULL_TURN << k);
    end
    red2_next = red1;
    for (int k = 3; k >= 0; k--) begin
      if (red2_next >= (FULL_TURN << k)) red2_next = red2_next - (FULL_TURN << k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red1 <= red1_next;
      red2 <= red2_next;
    end
  end

  // ---- quadrant split ----
  logic signed [25:0] ared;
  logic [24:0] a_u, rem_next, rem;
  logic [1:0]  quad_next, quad;

  always_comb begin
    ared = $signed({1'b0, red2[24:0]}) - $signed({1'b0, MOD_OFFSET});
    if (ared < 0) ared = ared + $signed({1'b0, FULL_TURN[24:0]});
    a_u = ared[24:0];
    if (a_u >= 25'(3 * QUARTER_TURN)) begin
      quad_next = 2'd3;
      rem_next  = a_u - 25'(3 * QUARTER_TURN);
    end else if (a_u >= 25'(2 * QUARTER_TURN)) begin
      quad_next = 2'd2;
      rem_next  = a_u - 25'(2 * QUARTER_TURN);
    end else if (a_u >= QUARTER_TURN) begin
      quad_next = 2'd1;
      rem_next  = a_u - QUARTER_TURN;
    end else begin
      quad_next = 2'd0;
      rem_next  = a_u;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      quad <= quad_next;
    end
  end

  // ---- degrees to radians, Q30 ----
  logic [49:0] rad_prod;
  logic [50:0] rad_sum;
  assign rad_prod = rem[22:0] * DEG_TO_RAD_Q32;
  assign rad_sum  = {1'b0, rad_prod} + 51'(1 << 17);

  // ---- CORDIC, one step per stage ----
  logic signed [33:0] cx [N+1];
  logic signed [33:0] cy [N+1];
  logic signed [33:0] cz [N+1];
  logic [1:0]         cq [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CORDIC_INV_GAIN;
      cy[0] <= '0;
      cz[0] <= $signed({1'b0, rad_sum[50:18]});
      cq[0] <= quad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][33]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed({2'b00, ATAN_Q30[i]});
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed({2'b00, ATAN_Q30[i]});
        end
        cq[i+1] <= cq[i];
      end
    end
  end

  // ---- cosine / sine, quadrant mapping ----
  function automatic logic signed [29:0] round_clamp(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd2) >>> 2;
    if (r > 34'(ONE_Q28)) return ONE_Q28;
    if (r < -34'(ONE_Q28)) return -ONE_Q28;
    return r[29:0];
  endfunction

  logic signed [29:0] cc, ss, cos_next, sin_next, sin_q;
  logic signed [31:0] c30_next, c30_a, c30_b, c30_c;
  logic signed [30:0] omc_next, omc_a, omc_b;

  always_comb begin
    cc = round_clamp(cx[N]);
    ss = round_clamp(cy[N]);
    case (cq[N])
      2'd0:    begin cos_next = cc;  sin_next = ss;  end
      2'd1:    begin cos_next = -ss; sin_next = cc;  end
      2'd2:    begin cos_next = -cc; sin_next = -ss; end
      default: begin cos_next = ss;  sin_next = -cc; end
    endcase
    c30_next = 32'(cos_next) <<< 2;
    omc_next = 31'(ONE_Q28) - 31'(cos_next);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sin_next;
      c30_a <= c30_next;
      omc_a <= omc_next;
    end
  end

  // ---- axis products (xx, yy, zz, xy, xz, yz) and sine products ----
  side_t sa;
  logic signed [35:0] pp [6];
  logic signed [47:0] sp [3];
  assign sa = side[4+N];

  always_ff @(posedge clk) begin
    if (en) begin
      pp[0] <= sa.axis_x * sa.axis_x;
      pp[1] <= sa.axis_y * sa.axis_y;
      pp[2] <= sa.axis_z * sa.axis_z;
      pp[3] <= sa.axis_x * sa.axis_y;
      pp[4] <= sa.axis_x * sa.axis_z;
      pp[5] <= sa.axis_y * sa.axis_z;
      sp[0] <= sa.axis_x * sin_q;
      sp[1] <= sa.axis_y * sin_q;
      sp[2] <= sa.axis_z * sin_q;
      c30_b <= c30_a;
      omc_b <= omc_a;
    end
  end

  // ---- one-minus-cos products ----
  logic signed [35:0] pr [6];
  logic signed [47:0] sr [3];
  logic signed [64:0] pt [6];
  logic signed [33:0] sn [3];

  always_comb begin
    for (int k = 0; k < 6; k++) pr[k] = (pp[k] + 36'sd2) >>> 2;
    for (int k = 0; k < 3; k++) sr[k] = (sp[k] + 48'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) pt[k] <= $signed(pr[k][33:0]) * omc_b;
      for (int k = 0; k < 3; k++) sn[k] <= sr[k][33:0];
      c30_c <= c30_b;
    end
  end

  // ---- matrix ----
  logic signed [64:0] pa [6];
  logic signed [39:0] pq [6];
  logic signed [39:0] m_next [9];
  logic signed [39:0] m [9];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pa[k] = (pt[k] + 65'sd134217728) >>> 28;
      pq[k] = pa[k][39:0];
    end
    m_next[0] = c30_c + pq[0];
    m_next[1] = pq[3] - sn[2];
    m_next[2] = pq[4] + sn[1];
    m_next[3] = pq[3] + sn[2];
    m_next[4] = c30_c + pq[1];
    m_next[5] = pq[5] - sn[0];
    m_next[6] = pq[4] - sn[1];
    m_next[7] = pq[5] + sn[0];
    m_next[8] = c30_c + pq[2];
  end

  always_ff @(posedge clk) begin
    if (en) m <= m_next;
  end

  // ---- matrix times vector, split into high and low vector halves ----
  side_t sv;
  logic signed [31:0] vv [3];
  logic signed [55:0] mh [9];
  logic signed [56:0] ml [9];
  assign sv = side[7+N];
  assign vv[0] = sv.vec_x;
  assign vv[1] = sv.vec_y;
  assign vv[2] = sv.vec_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          mh[r*3+j] <= m[r*3+j] * $signed(vv[j][31:16]);
          ml[r*3+j] <= m[r*3+j] * $signed({1'b0, vv[j][15:0]});
        end
      end
    end
  end

  logic signed [79:0] sh [3];
  logic signed [79:0] sl [3];
  logic signed [79:0] tot [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = 80'(mh[r*3]) + 80'(mh[r*3+1]) + 80'(mh[r*3+2]);
      sl[r] = 80'(ml[r*3]) + 80'(ml[r*3+1]) + 80'(ml[r*3+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) tot[r] <= (sh[r] <<< 16) + sl[r];
    end
  end

  // ---- round, saturate ----
  logic signed [79:0] rr [3];
  logic signed [31:0] res_next [3];
  logic               ovf_next;

  always_comb begin
    ovf_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      rr[r] = (tot[r] + 80'sd536870912) >>> 30;
      if (rr[r] > 80'sd2147483647) begin
        res_next[r] = 32'sh7FFFFFFF;
        ovf_next    = 1'b1;
      end else if (rr[r] < -80'sd2147483648) begin
        res_next[r] = 32'sh80000000;
        ovf_next    = 1'b1;
      end else begin
        res_next[r] = rr[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rot_x    <= res_next[0];
      dout.rot_y    <= res_next[1];
      dout.rot_z    <= res_next[2];
      dout.overflow <= ovf_next;
    end
  end

endmodule

// ----- test/aavr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_checker
// Watches both streams of the rotation unit, predicts each rotated vector
// from the accepted input and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module aavr_checker (
  input  logic            clk,
  input  logic            rst,
  aavr_in_if.sink         din,
  aavr_out_if.sink        dout,
  output int              errors,
  output int              n_results,
  output int              n_ovf,
  output int              pending
);
  import aavr_pkg::*;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               ovf;
  } rot_t;

  rot_t rot_q[$];

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void sin_cos(longint angle, output longint cs, output longint sn);
    longint a, q, r, x, y, z, nx, c, s;
    a = angle % longint'(FULL_TURN);
    if (a < 0) a += longint'(FULL_TURN);
    q = a / longint'(QUARTER_TURN);
    r = a - q * longint'(QUARTER_TURN);
    x = CORDIC_INV_GAIN;
    y = 0;
    z = fshr(r * longint'(DEG_TO_RAD_Q32) + (64'sd1 <<< 17), 18);
    for (int i = 0; i < TRIG_ITERATIONS && i < TABLE_LEN; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i);
        y  = y + fshr(x, i);
        z  = z - longint'(ATAN_Q30[i]);
      end else begin
        nx = x + fshr(y, i);
        y  = y - fshr(x, i);
        z  = z + longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    c = fshr(x + 2, 2);
    s = fshr(y + 2, 2);
    if (c > ONE_Q28) c = ONE_Q28;
    if (c < -longint'(ONE_Q28)) c = -longint'(ONE_Q28);
    if (s > ONE_Q28) s = ONE_Q28;
    if (s < -longint'(ONE_Q28)) s = -longint'(ONE_Q28);
    case (q & 3)
      0: begin cs = c;  sn = s;  end
      1: begin cs = -s; sn = c;  end
      2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  function automatic longint pair_q30(longint ai, longint aj, longint omc);
    return fshr(fshr(ai * aj + 2, 2) * omc + (64'sd1 <<< 27), 28);
  endfunction

  function automatic longint sine_q30(longint ai, longint s);
    return fshr(ai * s + (64'sd1 <<< 13), 14);
  endfunction

  function automatic logic signed [31:0] row_dot(longint m0, longint m1, longint m2,
      longint v0, longint v1, longint v2, inout logic ovf);
    longint m[3], v[3], shi, slo, vh, ah, al, res;
    m = '{m0, m1, m2};
    v = '{v0, v1, v2};
    shi = 0;
    slo = 0;
    for (int j = 0; j < 3; j++) begin
      vh = fshr(v[j], 16);
      shi += m[j] * vh;
      slo += m[j] * (v[j] - vh * 65536);
    end
    ah = fshr(shi, 14);
    al = shi - ah * 16384;
    res = ah + fshr(al * 65536 + slo + (64'sd1 <<< 29), 30);
    if (res > 64'sd2147483647) begin res = 64'sd2147483647; ovf = 1'b1; end
    if (res < -64'sd2147483648) begin res = -64'sd2147483648; ovf = 1'b1; end
    return res[31:0];
  endfunction

  function automatic rot_t rotate(longint vx, longint vy, longint vz,
      longint ax, longint ay, longint az, longint ang);
    rot_t   r;
    longint c, s, omc, c30, pxy, pxz, pyz;
    sin_cos(ang, c, s);
    omc = longint'(ONE_Q28) - c;
    c30 = c * 4;
    pxy = pair_q30(ax, ay, omc);
    pxz = pair_q30(ax, az, omc);
    pyz = pair_q30(ay, az, omc);
    r.ovf = 1'b0;
    r.rx = row_dot(c30 + pair_q30(ax, ax, omc), pxy - sine_q30(az, s),
                   pxz + sine_q30(ay, s), vx, vy, vz, r.ovf);
    r.ry = row_dot(pxy + sine_q30(az, s), c30 + pair_q30(ay, ay, omc),
                   pyz - sine_q30(ax, s), vx, vy, vz, r.ovf);
    r.rz = row_dot(pxz - sine_q30(ay, s), pyz + sine_q30(ax, s),
                   c30 + pair_q30(az, az, omc), vx, vy, vz, r.ovf);
    return r;
  endfunction

  assign pending = rot_q.size();

  always @(posedge clk) begin
    rot_t e;
    if (rst) begin
      errors <= 0;
      n_results <= 0;
      n_ovf <= 0;
    end else begin
      if (din.valid && din.ready)
        rot_q.push_back(rotate(din.vec_x, din.vec_y, din.vec_z, din.axis_x,
                               din.axis_y, din.axis_z, din.angle_deg));
      if (dout.valid && dout.ready) begin
        n_results <= n_results + 1;
        if (dout.overflow) n_ovf <= n_ovf + 1;
        if (rot_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h %h %h %b", $time,
                   dout.rot_x, dout.rot_y, dout.rot_z, dout.overflow);
          errors <= errors + 1;
        end else begin
          e = rot_q.pop_front();
          if (e.rx !== dout.rot_x || e.ry !== dout.rot_y || e.rz !== dout.rot_z ||
              e.ovf !== dout.overflow) begin
            $display("%0t: mismatch: expected %h %h %h %b, actual %h %h %h %b",
                     $time, e.rx, e.ry, e.rz, e.ovf,
                     dout.rot_x, dout.rot_y, dout.rot_z, dout.overflow);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random rotations into the unit with random gaps and
// output stalls, including one long stall that fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import aavr_pkg::*;

  localparam int N_RANDOM  = 1830;
  localparam int MAX_CYCLE = 400000;
  localparam int LONG_HOLD = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, n_results, n_ovf, pending;
  int   n_sent = 0;
  int   cycle = 0;
  logic hold_long = 1'b0;
  bit   stim_done = 1'b0;

  aavr_in_if  din ();
  aavr_out_if dout ();

  axis_angle_vector_rotation_unit dut (.clk(clk), .rst(rst), .din(din), .dout(dout));
  aavr_checker chk (.clk(clk), .rst(rst), .din(din), .dout(dout), .errors(errors),
                    .n_results(n_results), .n_ovf(n_ovf), .pending(pending));

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_vec(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic send(logic signed [31:0] vx, vy, vz, logic signed [17:0] ax, ay, az,
                      logic signed [31:0] ang);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.vec_x <= vx;
    din.vec_y <= vy;
    din.vec_z <= vz;
    din.axis_x <= ax;
    din.axis_y <= ay;
    din.axis_z <= az;
    din.angle_deg <= ang;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    n_sent++;
  endtask

  // unit axis along one of the six directions or the diagonal, or a random one that need not be unit
  task automatic pick_axis(output logic signed [17:0] ax, ay, az);
    int k;
    k = $urandom_range(0, 9);
    ax = 0; ay = 0; az = 0;
    case (k)
      0: ax = 18'sd65536;
      1: ax = -18'sd65536;
      2: ay = 18'sd65536;
      3: ay = -18'sd65536;
      4: az = 18'sd65536;
      5: az = -18'sd65536;
      6: begin ax = 18'sd37837; ay = -18'sd37837; az = 18'sd37837; end
      7: begin ax = 18'($urandom); ay = 18'($urandom); az = 18'($urandom); end
      default: begin
        ax = $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
        ay = $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
        az = $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
      end
    endcase
  endtask

  initial begin
    logic signed [17:0] ax, ay, az;
    logic signed [31:0] ang;
    int m;
    din.valid = 1'b0;
    din.vec_x = '0;
    din.vec_y = '0;
    din.vec_z = '0;
    din.axis_x = '0;
    din.axis_y = '0;
    din.axis_z = '0;
    din.angle_deg = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes of every field, quadrant edges, negative angles
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd0);
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd5898240);
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd11796480);
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd17694720);
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd23592960);
    send(32'sh0001_0000, 0, 0, 0, 0, 18'sd65536, 32'sd5898239);
    send(0, 32'sh0001_0000, 0, 18'sd65536, 0, 0, -32'sd2949120);
    send(0, 0, 32'sh0001_0000, 0, 18'sd65536, 0, 32'sh7fff_ffff);
    send(0, 0, 32'sh0001_0000, 0, 18'sd65536, 0, 32'sh8000_0000);
    send(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 18'sd37837, 18'sd37837,
         18'sd37837, 32'sd2949120);
    send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 0, 0, 32'sd0);
    send(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 18'sh1ffff, 18'sh1ffff,
         18'sh1ffff, 32'sd7000000);
    send(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 18'sh20000, 18'sh20000,
         18'sh20000, -32'sd1);
    send(32'sh4000_0000, 32'sh4000_0000, 0, 18'sh20000, 18'sh1ffff, 0, 32'sd11796480);
    send(32'hffff_ffff, 1, 32'hffff_ffff, 0, 0, 0, 32'sd1);
    send(32'sh0123_4567, -32'sh0765_4321, 32'sh0011_2233, 18'sd65536, 0, 0,
         -32'sd23592960);
    // random, mostly near unit axes and moderate vectors
    for (int i = 0; i < N_RANDOM; i++) begin
      pick_axis(ax, ay, az);
      m = $urandom_range(0, 9);
      case ($urandom_range(0, 4))
        0: ang = $urandom;
        1: ang = $urandom_range(0, 23592959);
        2: ang = $signed(32'($urandom_range(0, 47185920))) - 32'sd23592960;
        3: ang = 32'($urandom_range(0, 3)) * 32'd5898240 + 32'($urandom_range(0, 2)) - 1;
        default: ang = 32'($urandom_range(0, 7)) * 32'd2949120;
      endcase
      send(rand_vec(m < 2 ? 0 : (m < 6 ? 1 : 2)), rand_vec(m < 2 ? 0 : 1),
           rand_vec(m < 3 ? 0 : 2), ax, ay, az, ang);
    end
    din.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // long output hold once the run is under way, so the pipeline backs up
  initial begin
    wait (n_sent == 300);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    int stall;
    dout.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 8);
      if (cycle > 6000 && cycle < 8000) stall = 0;
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      while (hold_long) begin
        dout.ready <= 1'b0;
        @(posedge clk);
      end
      dout.ready <= 1'b1;
      @(posedge clk);
      while (!dout.valid && !hold_long) @(posedge clk);
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LEN + 10) @(posedge clk);
    $display("tb: %0d rotations sent, %0d results checked, %0d with saturation", n_sent,
             n_results, n_ovf);
    $display("tb: covered all quadrants, negative and extreme angles, odd axes, stalls");
    if (errors == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
src/aavr_pkg.sv
src/aavr_in_if.sv
src/aavr_out_if.sv
src/axis_angle_vector_rotation_unit.sv
test/aavr_checker.sv
test/tb.sv
